// File: rtl/bda_pkg.sv
// Package with shared widths, types and a helper function of the binary to decimal converter.
`default_nettype none

package bda_pkg;

	// Widths of the input value and the output character.
	localparam int VALUE_W = 32;
	localparam int CHAR_W = 6;

	// Decimal digits that a 32-bit value can need, and the width of one BCD digit.
	localparam int BCD_DIGITS = 10;
	localparam int DIGIT_W = 4;

	// Default for the most characters emitted per item.
	localparam int MAX_DIGITS_DEF = 10;

	// Counter width for the shift steps of one conversion.
	localparam int STEP_W = $clog2(VALUE_W);

	// Width of an index into the BCD digits.
	localparam int IDX_W = $clog2(BCD_DIGITS);

	// ASCII code of the character zero, as it fits in the output field.
	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef digit_t [BCD_DIGITS-1:0] bcd_t;

	// Commands from the sequencer to the shift-add-3 unit.
	typedef struct packed {
		logic load;
		logic step;
	} dab_ctrl_t;

	// Adjusts one BCD digit ahead of a left shift.
	function automatic digit_t add3(input digit_t d);
		digit_t r;
		if (d >= DIGIT_W'(5)) begin
			r = d + DIGIT_W'(3);
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/bda_in_if.sv
// Input channel: one binary value per word with a valid/ready handshake.
`default_nettype none

interface bda_in_if;
	logic valid;
	logic ready;
	logic [bda_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/bda_out_if.sv
// Output channel: one ASCII digit character per word with a valid/ready handshake.
`default_nettype none

interface bda_out_if;
	logic valid;
	logic ready;
	logic [bda_pkg::CHAR_W-1:0] digit_char;
	logic last;

	modport source (output valid, output digit_char, output last, input ready);
	modport sink (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/bda_dabble.sv
// Shift-add-3 unit that turns the binary value into BCD digits, one bit per step.
`default_nettype none

module bda_dabble (
	input  wire logic                          clk,
	input  wire bda_pkg::dab_ctrl_t            ctrl,
	input  wire logic [bda_pkg::VALUE_W-1:0]   value,
	output bda_pkg::bcd_t                      bcd
);

	localparam int BCD_W = bda_pkg::BCD_DIGITS * bda_pkg::DIGIT_W;

	logic [bda_pkg::VALUE_W-1:0] bin_q;
	bda_pkg::bcd_t               bcd_q;
	bda_pkg::bcd_t               bcd_adj;
	logic [BCD_W-1:0]            bcd_flat;

	// Every digit of five or more gets three added before the shift.
	always_comb begin
		for (int i = 0; i < bda_pkg::BCD_DIGITS; i++) begin
			bcd_adj[i] = bda_pkg::add3(bcd_q[i]);
		end
		bcd_flat = bcd_adj;
	end

	// Load clears the digits; each step shifts the top binary bit into the BCD word.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			bin_q <= {bin_q[bda_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_flat[BCD_W-2:0], bin_q[bda_pkg::VALUE_W-1]};
		end
	end

	assign bcd = bcd_q;

endmodule

`default_nettype wire

// File: rtl/bda_emit.sv
// Emitter: skips the leading zeros of uncut values, sends digits via an output register.
`default_nettype none

module bda_emit #(
	parameter int MAX_DIGITS = bda_pkg::MAX_DIGITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bda_pkg::bcd_t bcd,
	input  wire logic          start,
	output logic               done,
	bda_out_if.source          dout
);

	// Highest digit position that may be emitted.
	localparam int TOP_IDX =
		((MAX_DIGITS < bda_pkg::BCD_DIGITS) ? MAX_DIGITS : bda_pkg::BCD_DIGITS) - 1;

	logic                        busy_q;
	logic                        seen_q;
	logic [bda_pkg::IDX_W-1:0]   idx_q;
	logic                        valid_q;
	logic [bda_pkg::CHAR_W-1:0]  char_q;
	logic                        last_q;
	bda_pkg::digit_t             digit;
	logic                        adv;
	logic                        skip;
	logic                        load;
	logic                        trunc;

	// A nonzero digit above the top allowed position means the value is cut, so every
	// allowed position is sent, zeros included.
	always_comb begin
		trunc = 1'b0;
		for (int i = 0; i < bda_pkg::BCD_DIGITS; i++) begin
			if (i > TOP_IDX) begin
				trunc = trunc | (bcd[i] != '0);
			end
		end
	end

	// The current digit moves on when the output register is free or being emptied.
	always_comb begin
		digit = bcd[idx_q];
		adv   = busy_q && (!valid_q || dout.ready);
		skip  = (digit == '0) && !seen_q && !trunc && (idx_q != '0);
		load  = adv && !skip;
		done  = load && (idx_q == '0);
	end

	// Control of the digit walk, from the top position down to the units digit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			seen_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && !dout.ready);
			if (start) begin
				busy_q <= 1'b1;
				seen_q <= 1'b0;
				idx_q  <= bda_pkg::IDX_W'(TOP_IDX);
			end else if (adv) begin
				if (load) begin
					seen_q  <= 1'b1;
				end
				if (idx_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= bda_pkg::ASCII_ZERO + bda_pkg::CHAR_W'(digit);
			last_q <= (idx_q == '0);
		end
	end

	assign dout.valid      = valid_q;
	assign dout.digit_char = char_q;
	assign dout.last       = last_q;

endmodule

`default_nettype wire

// File: rtl/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter with its sequencer.
`default_nettype none

// Converts one unsigned 32-bit value per input word into its decimal text, one ASCII digit
// character per output word, most significant digit first, without leading zeros; zero
// gives the single character '0' and the units digit carries last. With MAX_DIGITS below
// ten only that many low digits are sent, and when higher digits are dropped the zeros
// among the sent ones are kept. An item is first shifted through the shift-add-3 unit, one
// step per input bit; then one digit position per cycle is walked, while the output is not
// stalled, from the top allowed position down to the units (ten with the default), and the
// next value is taken in the idle state that follows. The input is not ready while an item
// is being converted or its digits are being walked; the last character may still wait in
// the output register while the next value is taken.

module binary_to_decimal_ascii #(
	parameter int MAX_DIGITS = bda_pkg::MAX_DIGITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bda_in_if.sink    din,
	bda_out_if.source dout
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                 state_q;
	logic [bda_pkg::STEP_W-1:0] step_cnt_q;
	bda_pkg::dab_ctrl_t         dab_ctrl;
	logic                       emit_start;
	logic                       emit_done;
	bda_pkg::bcd_t              bcd;
	logic                       accept;
	logic                       last_step;

	// Sequencer commands to the shift-add-3 unit and the emitter.
	always_comb begin
		accept        = din.valid && (state_q == ST_IDLE);
		last_step     = (step_cnt_q == bda_pkg::STEP_W'(bda_pkg::VALUE_W - 1));
		dab_ctrl.load = accept;
		dab_ctrl.step = (state_q == ST_CONV);
		emit_start    = (state_q == ST_CONV) && last_step;
	end

	assign din.ready = (state_q == ST_IDLE);

	// State machine: idle, convert for one step per input bit, then walk the digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_CONV;
						step_cnt_q <= '0;
					end
				end
				ST_CONV: begin
					step_cnt_q <= step_cnt_q + 1'b1;
					if (last_step) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	bda_dabble u_dabble (
		.clk   (clk),
		.ctrl  (dab_ctrl),
		.value (din.value),
		.bcd   (bcd)
	);

	bda_emit #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.bcd    (bcd),
		.start  (emit_start),
		.done   (emit_done),
		.dout   (dout)
	);

	// An accepted word starts a conversion at step zero and blocks the input.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> (state_q == ST_CONV) && (step_cnt_q == '0) && !din.ready)
		else $error("accepted word did not start a conversion");

	// Every character sent is a decimal digit.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.digit_char >= bda_pkg::ASCII_ZERO) &&
			(dout.digit_char <= bda_pkg::ASCII_ZERO + bda_pkg::CHAR_W'(9)))
		else $error("output character is not a decimal digit");

	// The emitter finishes only while the sequencer waits for it.
	a_done_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_done |-> (state_q == ST_EMIT))
		else $error("emitter finished outside of the emit phase");

endmodule

`default_nettype wire
